FILE: rtl/core/mtws_pkg.sv
// Package with the MT19937 constants and the per-word seed, twist and temper functions.
`default_nettype none
package mtws_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;
  localparam int unsigned IDX_W         = 10;

  localparam logic [WORD_W-1:0] SEED_MULT     = 32'd1812433253;
  localparam logic [WORD_W-1:0] SEED_DEFAULT  = 32'd5489;
  localparam logic [WORD_W-1:0] TWIST_MATRIX  = 32'h9908b0df;
  localparam logic [WORD_W-1:0] TEMPER_MASK_B = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_MASK_C = 32'hefc60000;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    logic  busy;
    logic  load;
    word_t word;
  } seed_ctrl_t;

  function automatic word_t seed_next(input word_t prev, input idx_t idx);
    word_t mixed;
    word_t prod;
    begin
      mixed = prev ^ (prev >> 30);
      prod  = mixed * SEED_MULT;
      return prod + word_t'(idx);
    end
  endfunction

  function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t mid);
    word_t y;
    word_t mix;
    begin
      y   = {cur[WORD_W-1], nxt[WORD_W-2:0]};
      mix = y[0] ? TWIST_MATRIX : '0;
      return mid ^ (y >> 1) ^ mix;
    end
  endfunction

  function automatic word_t temper_word(input word_t w);
    word_t y;
    begin
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_MASK_B);
      y = y ^ ((y << 15) & TEMPER_MASK_C);
      y = y ^ (y >> 18);
      return (y == '0) ? word_t'(1) : y;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mtws_cell.sv
// One state word of the circular shift chain.
`default_nettype none
module mtws_cell (
  input  wire logic           clk,
  input  wire logic           shift_en,
  input  wire mtws_pkg::word_t d,
  output mtws_pkg::word_t     q
);
  import mtws_pkg::*;

  word_t word_r;
  word_t word_nxt;

  assign word_nxt = shift_en ? d : word_r;

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule
`default_nettype wire

FILE: rtl/core/mtws_seeder.sv
// Seed sequencer: feeds the 624 initialization words into the chain tail.
`default_nettype none
module mtws_seeder (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            seed_start,
  input  wire mtws_pkg::word_t seed_value,
  input  wire mtws_pkg::word_t last_word,
  output mtws_pkg::seed_ctrl_t ctrl
);
  import mtws_pkg::*;

  logic  busy_r;
  logic  busy_nxt;
  idx_t  cnt_r;
  idx_t  cnt_nxt;
  word_t seed_r;
  word_t seed_nxt;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    seed_nxt = seed_r;
    if (seed_start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      seed_nxt = seed_value;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + idx_t'(1);
      if (cnt_r == idx_t'(STATE_WORDS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      seed_r <= SEED_DEFAULT;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      seed_r <= seed_nxt;
    end
  end

  assign ctrl.busy = busy_r;
  assign ctrl.load = busy_r;
  assign ctrl.word = (cnt_r == '0) ? seed_r : seed_next(last_word, cnt_r);

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r < idx_t'(STATE_WORDS)))
    else $error("seed count out of range");

  a_fill_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> ($past(cnt_r) == idx_t'(STATE_WORDS - 1)))
    else $error("seed fill ended early");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    seed_start |-> !busy_r)
    else $error("reseed started while busy");

endmodule
`default_nettype wire

FILE: rtl/core/mersenne_twister_word_source.sv
// Top level: MT19937 word source built as a circular chain of 624 word cells.
// Draw: result strobed on out_valid in the cycle after the transaction; one draw per cycle while not busy.
// Each draw twists the head word into the chain tail and tempers it, so no full-state twist pause.
// Reseed: busy high while the seed recurrence fills the chain tail with 624 words.
// Reset: same fill with seed 5489; busy high throughout, no transaction taken.
// The receiver cannot stall; each result is valid for exactly one cycle.
`default_nettype none
module mersenne_twister_word_source (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            in_command,
  input  wire mtws_pkg::word_t in_seed_value,
  output logic                 out_valid,
  output mtws_pkg::word_t      out_random_word
);
  import mtws_pkg::*;

  word_t      cells [STATE_WORDS];
  word_t      tail_d;
  word_t      twisted;
  logic       draw;
  logic       reseed;
  logic       shift_en;
  seed_ctrl_t sctrl;

  logic  out_valid_r;
  logic  out_valid_nxt;
  word_t out_word_r;
  word_t out_word_nxt;

  assign draw   = start && !sctrl.busy && !in_command;
  assign reseed = start && !sctrl.busy && in_command;

  mtws_seeder u_seeder (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed_start (reseed),
    .seed_value (in_seed_value),
    .last_word  (cells[STATE_WORDS-1]),
    .ctrl       (sctrl)
  );

  assign twisted  = twist_word(cells[0], cells[1], cells[MIDDLE_OFFSET]);
  assign shift_en = sctrl.load || draw;
  assign tail_d   = sctrl.load ? sctrl.word : twisted;

  for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
    if (i == STATE_WORDS - 1) begin : g_tail
      mtws_cell u_cell (.clk(clk), .shift_en(shift_en), .d(tail_d), .q(cells[i]));
    end else begin : g_body
      mtws_cell u_cell (.clk(clk), .shift_en(shift_en), .d(cells[i+1]), .q(cells[i]));
    end
  end

  assign out_valid_nxt = draw;
  assign out_word_nxt  = temper_word(twisted);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  assign busy            = sctrl.busy;
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  a_valid_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(start && !busy && !in_command))
    else $error("result without draw transaction");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r != '0))
    else $error("zero word delivered");

  a_reseed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command) |=> busy)
    else $error("reseed did not raise busy");

  a_no_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(busy) |-> !out_valid_r)
    else $error("result while filling state");

endmodule
`default_nettype wire
